>>> rtl/core/sirs_lattice_site_update_defines.svh
`ifndef SIRS_LATTICE_SITE_UPDATE_DEFINES_SVH
`define SIRS_LATTICE_SITE_UPDATE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SLS_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/sls_pkg.sv
`timescale 1ns / 1ps

package sls_pkg;

   localparam int SIDE_DEFAULT  = 64;
   localparam int FRACTION_BITS = 16;
   localparam int RATE_W        = FRACTION_BITS + 1;
   localparam int COORD_IN_W    = 6;
   localparam int COUNT_PORT_W  = 13;
   localparam int STEP_W        = 32;
   localparam int CSR_INDEX_W   = 2;

   typedef enum logic [1:0] {
      ST_RECOVERED   = 2'd0,
      ST_SUSCEPTIBLE = 2'd1,
      ST_INFECTED    = 2'd2
   } site_state_type;

   typedef enum logic [1:0] {
      CTL_CLEAR,
      CTL_IDLE,
      CTL_DECIDE
   } ctl_state_type;

   localparam logic MODE_SEED   = 1'b0;
   localparam logic MODE_UPDATE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMMUNITY_LOSS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INFECTION     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECOVERY      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED_FRACTION = 2'd3;

endpackage

>>> rtl/core/sls_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
// Read during write to the same address returns the old word.
module sls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/sirs_lattice_site_update.sv
// Channel   Direction  Handshake                Payload
// req_      in         req_valid / req_stall    mode, site_row, site_col, rand_fraction
// rsp_      out        rsp_valid / rsp_stall    applied, site_state, three counts, update_count
// csr_      in         csr_valid / csr_ready    csr_index, csr_wdata (17-bit rates)
//
// Each transaction: the accept edge launches the row reads; the decide cycle then
// decides, writes the row back and loads the result register once that register is free.
// This order is set by the registered reads of the lattice memories and the
// read-modify-write of the site's row.
// After reset a clearing pass writes every row susceptible, with req_stall high.
// A stalled result holds the block in its decide cycle; req_stall stays high meanwhile.
`timescale 1ns / 1ps
`include "sirs_lattice_site_update_defines.svh"

module sirs_lattice_site_update
   import sls_pkg::*;
#(
   parameter int SIDE = SIDE_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_mode,
   input  logic [COORD_IN_W-1:0]   req_site_row,
   input  logic [COORD_IN_W-1:0]   req_site_col,
   input  logic [FRACTION_BITS-1:0] req_rand_fraction,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_applied,
   output logic [1:0]              rsp_site_state,
   output logic [COUNT_PORT_W-1:0] rsp_susceptible_count,
   output logic [COUNT_PORT_W-1:0] rsp_infected_count,
   output logic [COUNT_PORT_W-1:0] rsp_recovered_count,
   output logic [STEP_W-1:0]       rsp_update_count,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [RATE_W-1:0]       csr_wdata
);

   localparam int COORD_W = (SIDE > 1) ? $clog2(SIDE) : 1;
   localparam int SITES   = SIDE * SIDE;
   localparam int CNT_W   = $clog2(SITES + 1);
   localparam int SUM_W   = CNT_W + 2;
   localparam int ROW_W   = 2 * SIDE;
   localparam int PROD_W  = RATE_W + 3;

   // ------------------------------------------------------------------
   // Coordinate helpers. The 6-bit port value is reduced modulo SIDE by
   // greedy compare-and-subtract of SIDE shifted down bit by bit.
   // ------------------------------------------------------------------
   function automatic logic [COORD_W-1:0] wrap_coord(input logic [COORD_IN_W-1:0] v);
      logic [COORD_IN_W-1:0] t;
      t = v;
      for (int k = COORD_IN_W - 1; k >= 0; k--) begin
         if (32'(t) >= (32'(SIDE) << k)) begin
            t = t - COORD_IN_W'(32'(SIDE) << k);
         end
      end
      return COORD_W'(t);
   endfunction

   function automatic logic [COORD_W-1:0] prev_coord(input logic [COORD_W-1:0] v);
      return (v == '0) ? COORD_W'(SIDE - 1) : v - COORD_W'(1);
   endfunction

   function automatic logic [COORD_W-1:0] next_coord(input logic [COORD_W-1:0] v);
      return (v == COORD_W'(SIDE - 1)) ? '0 : v + COORD_W'(1);
   endfunction

   // ------------------------------------------------------------------
   // Control and stored state
   // ------------------------------------------------------------------
   ctl_state_type             ctl_state_ff, ctl_state_in;
   logic [COORD_W-1:0]        clr_row_ff, clr_row_in;

   // latched transaction
   logic                      mode_ff;
   logic [COORD_W-1:0]        row_ff;
   logic [COORD_W-1:0]        col_ff;
   logic [FRACTION_BITS-1:0]  rnd_ff;

   // rate registers
   logic [RATE_W-1:0]         immunity_loss_ff;
   logic [RATE_W-1:0]         infection_ff;
   logic [RATE_W-1:0]         recovery_ff;
   logic [RATE_W-1:0]         seed_fraction_ff;

   // population counts and step counter
   logic [CNT_W-1:0]          sus_cnt_ff, sus_cnt_in;
   logic [CNT_W-1:0]          inf_cnt_ff, inf_cnt_in;
   logic [CNT_W-1:0]          rec_cnt_ff, rec_cnt_in;
   logic [STEP_W-1:0]         steps_ff, steps_in;

   // result register
   logic                      rsp_valid_ff;
   logic                      rsp_applied_ff;
   site_state_type            rsp_state_ff;
   logic [COUNT_PORT_W-1:0]   rsp_sus_ff;
   logic [COUNT_PORT_W-1:0]   rsp_inf_ff;
   logic [COUNT_PORT_W-1:0]   rsp_rec_ff;
   logic [STEP_W-1:0]         rsp_steps_ff;

   logic                      req_accept;
   logic                      rsp_free;
   logic                      finish;

   // ------------------------------------------------------------------
   // Lattice memories. The state RAM holds one row per word, two bits a
   // site. Two copies of an infected-bit map give the rows above and
   // below in the same cycle as the site's own row.
   // ------------------------------------------------------------------
   logic [COORD_W-1:0]        rd_row, rd_up, rd_dn;
   logic                      wr_en;
   logic [COORD_W-1:0]        wr_row;
   logic [ROW_W-1:0]          state_wr_data, row_q, row_new;
   logic [SIDE-1:0]           inf_wr_data, inf_new, up_q, dn_q;

   assign req_stall  = (ctl_state_ff != CTL_IDLE);
   assign req_accept = req_valid && (ctl_state_ff == CTL_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign finish     = (ctl_state_ff == CTL_DECIDE) && rsp_free;

   // Reads launch on the accept edge from the port, then hold on the
   // latched row so a stalled decide cycle keeps seeing the same words.
   assign rd_row = (ctl_state_ff == CTL_IDLE) ? wrap_coord(req_site_row) : row_ff;
   assign rd_up  = prev_coord(rd_row);
   assign rd_dn  = next_coord(rd_row);

   assign wr_en         = (ctl_state_ff == CTL_CLEAR) || finish;
   assign wr_row        = (ctl_state_ff == CTL_CLEAR) ? clr_row_ff : row_ff;
   assign state_wr_data = (ctl_state_ff == CTL_CLEAR) ? {SIDE{2'(ST_SUSCEPTIBLE)}} : row_new;
   assign inf_wr_data   = (ctl_state_ff == CTL_CLEAR) ? '0 : inf_new;

   sls_ram #(.WIDTH(ROW_W), .DEPTH(SIDE)) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_row),
      .wr_data (state_wr_data),
      .rd_addr (rd_row),
      .rd_data (row_q)
   );

   sls_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_inf_up_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_row),
      .wr_data (inf_wr_data),
      .rd_addr (rd_up),
      .rd_data (up_q)
   );

   sls_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_inf_dn_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_row),
      .wr_data (inf_wr_data),
      .rd_addr (rd_dn),
      .rd_data (dn_q)
   );

   // ------------------------------------------------------------------
   // Decide: site transition, count moves, step count, row write-back
   // ------------------------------------------------------------------
   site_state_type            old_st, new_st;
   logic                      absorbing;
   logic                      applied_c;
   logic [COORD_W-1:0]        col_lf, col_rt;
   logic [2:0]                inf_nbrs;
   logic                      inf_hit;

   assign col_lf = prev_coord(col_ff);
   assign col_rt = next_coord(col_ff);

   always_comb begin
      old_st    = site_state_type'(row_q[{col_ff, 1'b0} +: 2]);
      inf_nbrs  = {2'b00, up_q[col_ff]} + {2'b00, dn_q[col_ff]}
                + {2'b00, row_q[{col_lf, 1'b1}]} + {2'b00, row_q[{col_rt, 1'b1}]};
      // 4*rand < n*rate, both sides at product width
      inf_hit   = PROD_W'({rnd_ff, 2'b00}) < (PROD_W'(inf_nbrs) * PROD_W'(infection_ff));
      absorbing = (mode_ff == MODE_UPDATE)
               && ((inf_cnt_ff == '0) || (inf_cnt_ff == CNT_W'(SITES)));
      applied_c = !absorbing;

      new_st = old_st;
      if (mode_ff == MODE_SEED) begin
         new_st = (RATE_W'(rnd_ff) < seed_fraction_ff) ? ST_INFECTED : ST_SUSCEPTIBLE;
      end else if (!absorbing) begin
         case (old_st)
            ST_INFECTED: begin
               if (RATE_W'(rnd_ff) < recovery_ff) new_st = ST_RECOVERED;
            end
            ST_RECOVERED: begin
               if (RATE_W'(rnd_ff) < immunity_loss_ff) new_st = ST_SUSCEPTIBLE;
            end
            default: begin
               if (inf_hit) new_st = ST_INFECTED;
            end
         endcase
      end

      sus_cnt_in = sus_cnt_ff;
      inf_cnt_in = inf_cnt_ff;
      rec_cnt_in = rec_cnt_ff;
      if (new_st != old_st) begin
         case (old_st)
            ST_INFECTED:  inf_cnt_in = inf_cnt_in - CNT_W'(1);
            ST_RECOVERED: rec_cnt_in = rec_cnt_in - CNT_W'(1);
            default:      sus_cnt_in = sus_cnt_in - CNT_W'(1);
         endcase
         case (new_st)
            ST_INFECTED:  inf_cnt_in = inf_cnt_in + CNT_W'(1);
            ST_RECOVERED: rec_cnt_in = rec_cnt_in + CNT_W'(1);
            default:      sus_cnt_in = sus_cnt_in + CNT_W'(1);
         endcase
      end

      steps_in = steps_ff;
      if ((mode_ff == MODE_UPDATE) && !absorbing && (steps_ff != '1)) begin
         steps_in = steps_ff + STEP_W'(1);
      end

      row_new = row_q;
      row_new[{col_ff, 1'b0} +: 2] = new_st;
      // infected map is the upper bit of each site code
      for (int k = 0; k < SIDE; k++) begin
         inf_new[k] = row_new[2 * k + 1];
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_state_ff <= CTL_CLEAR;
         clr_row_ff   <= '0;
      end else begin
         ctl_state_ff <= ctl_state_in;
         clr_row_ff   <= clr_row_in;
      end
   end

   always_comb begin
      ctl_state_in = ctl_state_ff;
      clr_row_in   = clr_row_ff;
      case (ctl_state_ff)
         CTL_CLEAR: begin
            clr_row_in = clr_row_ff + COORD_W'(1);
            if (clr_row_ff == COORD_W'(SIDE - 1)) begin
               clr_row_in   = '0;
               ctl_state_in = CTL_IDLE;
            end
         end
         CTL_IDLE: begin
            if (req_accept) ctl_state_in = CTL_DECIDE;
         end
         CTL_DECIDE: begin
            if (rsp_free) ctl_state_in = CTL_IDLE;
         end
         default: begin
            ctl_state_in = CTL_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Rate registers; the port is always ready
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         immunity_loss_ff <= '0;
         infection_ff     <= '0;
         recovery_ff      <= '0;
         seed_fraction_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMMUNITY_LOSS: immunity_loss_ff <= csr_wdata;
            CSR_INFECTION:     infection_ff     <= csr_wdata;
            CSR_RECOVERY:      recovery_ff      <= csr_wdata;
            CSR_SEED_FRACTION: seed_fraction_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Counts, step counter and result register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sus_cnt_ff   <= CNT_W'(SITES);
         inf_cnt_ff   <= '0;
         rec_cnt_ff   <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (finish) begin
            sus_cnt_ff   <= sus_cnt_in;
            inf_cnt_ff   <= inf_cnt_in;
            rec_cnt_ff   <= rec_cnt_in;
            steps_ff     <= steps_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff <= req_mode;
         row_ff  <= rd_row;
         col_ff  <= wrap_coord(req_site_col);
         rnd_ff  <= req_rand_fraction;
      end
      if (finish) begin
         rsp_applied_ff <= applied_c;
         rsp_state_ff   <= new_st;
         rsp_sus_ff     <= COUNT_PORT_W'(sus_cnt_in);
         rsp_inf_ff     <= COUNT_PORT_W'(inf_cnt_in);
         rsp_rec_ff     <= COUNT_PORT_W'(rec_cnt_in);
         rsp_steps_ff   <= steps_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_applied           = rsp_applied_ff;
   assign rsp_site_state        = rsp_state_ff;
   assign rsp_susceptible_count = rsp_sus_ff;
   assign rsp_infected_count    = rsp_inf_ff;
   assign rsp_recovered_count   = rsp_rec_ff;
   assign rsp_update_count      = rsp_steps_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   logic [SUM_W-1:0] count_sum;

   assign count_sum = SUM_W'(sus_cnt_ff) + SUM_W'(inf_cnt_ff) + SUM_W'(rec_cnt_ff);

   `SLS_ASSERT_HOLDS(a_counts_cover_lattice, clock, reset, ctl_state_ff != CTL_CLEAR, count_sum == SUM_W'(SITES), "site counts do not add up to the lattice size")
   `SLS_ASSERT_NEXT(a_accept_to_decide, clock, reset, req_valid && !req_stall, ctl_state_ff == CTL_DECIDE, "accepted transaction did not reach the decide cycle")
   `SLS_ASSERT_NEXT(a_absorbing_no_change, clock, reset, finish && !applied_c, $stable(inf_cnt_ff) && $stable(steps_ff), "absorbing update changed counts or steps")

endmodule
